// ===== design/pvu_pkg.sv =====
// ----------------------------------------------------------------------------
// pvu_pkg
// shared types, widths and the arctangent table of the polar vector unit
// ----------------------------------------------------------------------------
package pvu_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int ANGLE_WIDTH = 16;
    localparam int GUARD       = 16;
    // rotation lane: |x|,|y| stay below 1.65 * 2^(COORD_WIDTH+GUARD)
    localparam int RW          = COORD_WIDTH + GUARD + 2;
    // vectoring lane: sum of two vectors, then cordic growth
    localparam int VW          = COORD_WIDTH + GUARD + 4;
    localparam int ROT_ZW      = 33;
    localparam logic [31:0] KGAIN = 32'd2608131496;

    typedef enum logic [1:0] {
        ACT_TO_CART  = 2'd0,
        ACT_TO_POLAR = 2'd1,
        ACT_ADD      = 2'd2,
        ACT_SUB      = 2'd3
    } t_action;

    typedef struct packed {
        t_action                         action;
        logic [COORD_WIDTH-1:0]          a_magnitude;
        logic signed [ANGLE_WIDTH-1:0]   a_angle;
        logic [COORD_WIDTH-1:0]          b_magnitude;
        logic signed [ANGLE_WIDTH-1:0]   b_angle;
        logic signed [COORD_WIDTH-1:0]   point_x;
        logic signed [COORD_WIDTH-1:0]   point_y;
    } t_operands;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0]   out_x;
        logic signed [COORD_WIDTH-1:0]   out_y;
        logic [COORD_WIDTH-1:0]          out_magnitude;
        logic signed [ANGLE_WIDTH-1:0]   out_angle;
        logic                            overflow;
    } t_result;

    // rotation mode lane
    typedef struct packed {
        logic signed [RW-1:0]     x;
        logic signed [RW-1:0]     y;
        logic signed [ROT_ZW-1:0] z;
    } t_rot;

    // vectoring mode lane, angle wraps modulo 2*pi
    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic [31:0]          z;
    } t_vec;

    // atan(2^-i) in units of pi/2^31
    function automatic logic [31:0] atan_angle(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10680862;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            5'd24:   a = 32'd41;
            5'd25:   a = 32'd20;
            5'd26:   a = 32'd10;
            5'd27:   a = 32'd5;
            5'd28:   a = 32'd3;
            5'd29:   a = 32'd1;
            5'd30:   a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== design/pvu_rot_step.sv =====
// ----------------------------------------------------------------------------
// pvu_rot_step
// one registered cordic micro-rotation in rotation mode
// ----------------------------------------------------------------------------
module pvu_rot_step #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  pvu_pkg::t_rot i_s,
    output pvu_pkg::t_rot o_s
);

    logic signed [pvu_pkg::RW-1:0]     dx;
    logic signed [pvu_pkg::RW-1:0]     dy;
    logic signed [pvu_pkg::ROT_ZW-1:0] at;
    pvu_pkg::t_rot                     n_s;
    pvu_pkg::t_rot                     r_s;

    always_comb begin
        dx = i_s.y >>> STEP;
        dy = i_s.x >>> STEP;
        at = signed'({1'b0, pvu_pkg::atan_angle(5'(STEP))});
        if (!i_s.z[pvu_pkg::ROT_ZW-1]) begin
            n_s.x = i_s.x - dx;
            n_s.y = i_s.y + dy;
            n_s.z = i_s.z - at;
        end else begin
            n_s.x = i_s.x + dx;
            n_s.y = i_s.y - dy;
            n_s.z = i_s.z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;
    end

    assign o_s = r_s;

endmodule

// ===== design/pvu_vec_step.sv =====
// ----------------------------------------------------------------------------
// pvu_vec_step
// one registered cordic micro-rotation in vectoring mode
// ----------------------------------------------------------------------------
module pvu_vec_step #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  pvu_pkg::t_vec i_s,
    output pvu_pkg::t_vec o_s
);

    logic signed [pvu_pkg::VW-1:0] dx;
    logic signed [pvu_pkg::VW-1:0] dy;
    logic [31:0]                   at;
    pvu_pkg::t_vec                 n_s;
    pvu_pkg::t_vec                 r_s;

    always_comb begin
        dx = i_s.y >>> STEP;
        dy = i_s.x >>> STEP;
        at = pvu_pkg::atan_angle(5'(STEP));
        if (!i_s.y[pvu_pkg::VW-1]) begin
            n_s.x = i_s.x + dx;
            n_s.y = i_s.y - dy;
            n_s.z = i_s.z + at;
        end else begin
            n_s.x = i_s.x - dx;
            n_s.y = i_s.y + dy;
            n_s.z = i_s.z - at;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;
    end

    assign o_s = r_s;

endmodule

// ===== design/pvu_gain.sv =====
// ----------------------------------------------------------------------------
// pvu_gain
// two-stage removal of the cordic gain, rounded half away from zero
// ----------------------------------------------------------------------------
module pvu_gain #(
    parameter int W = 34
) (
    input  logic                i_clk,
    input  logic signed [W-1:0] i_v,
    output logic signed [W-1:0] o_p
);

    localparam int HW = W - 32;

    logic [W-1:0]        n_u;
    logic                r_neg;
    logic [63:0]         r_plo;
    logic [HW+31:0]      r_phi;
    logic [W-1:0]        n_sum;
    logic signed [W-1:0] r_p;

    always_comb begin
        n_u = i_v[W-1] ? W'(-i_v) : W'(i_v);
    end

    // first stage: split magnitude into low word and high part
    always_ff @(posedge i_clk) begin
        r_neg <= i_v[W-1];
        r_plo <= 64'(n_u[31:0]) * 64'(pvu_pkg::KGAIN);
        r_phi <= (HW+32)'(n_u[W-1:32]) * (HW+32)'(pvu_pkg::KGAIN);
    end

    always_comb begin
        n_sum = W'(r_phi) + W'((r_plo + 64'h0000_0000_8000_0000) >> 32);
    end

    always_ff @(posedge i_clk) begin
        r_p <= r_neg ? signed'(W'(-n_sum)) : signed'(n_sum);
    end

    assign o_p = r_p;

endmodule

// ===== design/polar_vector_unit.sv =====
// ----------------------------------------------------------------------------
// polar_vector_unit
// fixed-point polar/cartesian converter and polar adder built on cordic
// ----------------------------------------------------------------------------
// takes one item in every clock cycle (busy is always low) and gives its
// result with o_valid high for a single cycle; the receiver cannot stall,
// and none is needed since the pipeline never holds. the datapath is two
// cordic chains in series, one registered micro-rotation per stage: a
// rotation chain (two lanes, a and b) followed by a vectoring chain, each
// followed by a two-stage gain multiplier. action 0 yields out_x/out_y, the
// others out_magnitude/out_angle; unused fields read zero, a zero magnitude
// gives angle zero, and any saturated field raises overflow
module polar_vector_unit #(
    parameter int ROTATION_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  pvu_pkg::t_operands i_operands,
    output logic               o_valid,
    output pvu_pkg::t_result   o_result
);

    localparam int N       = ROTATION_STEPS;
    localparam int RW      = pvu_pkg::RW;
    localparam int VW      = pvu_pkg::VW;
    localparam int UW      = VW - pvu_pkg::GUARD + 1;
    localparam int LATENCY = 2 * ROTATION_STEPS + 8;

    localparam logic signed [32:0] QUARTER_TURN = 33'sh0_4000_0000;
    localparam logic signed [32:0] HALF_TURN    = 33'sh0_8000_0000;
    localparam logic signed [UW-1:0] SMAX = UW'(2**(pvu_pkg::COORD_WIDTH-1) - 1);
    localparam logic signed [UW-1:0] SMIN = -UW'(2**(pvu_pkg::COORD_WIDTH-1));
    localparam logic signed [UW-1:0] UMAX = UW'(2**pvu_pkg::COORD_WIDTH - 1);

    // sideband carried alongside the rotation lanes
    typedef struct packed {
        pvu_pkg::t_action                         action;
        logic signed [pvu_pkg::COORD_WIDTH-1:0]   px;
        logic signed [pvu_pkg::COORD_WIDTH-1:0]   py;
    } t_side1;

    // sideband carried alongside the vectoring lane
    typedef struct packed {
        pvu_pkg::t_action     action;
        logic signed [RW-1:0] ax;
        logic signed [RW-1:0] ay;
    } t_side2;

    // map magnitude/angle into the rotation range, folding the far half-plane
    function automatic pvu_pkg::t_rot pre_rotate(
        input logic [pvu_pkg::COORD_WIDTH-1:0]        mag,
        input logic signed [pvu_pkg::ANGLE_WIDTH-1:0] ang
    );
        pvu_pkg::t_rot     r;
        logic signed [32:0] z;
        z   = 33'(signed'({ang, {(32 - pvu_pkg::ANGLE_WIDTH){1'b0}}}));
        r.x = signed'(RW'({mag, {pvu_pkg::GUARD{1'b0}}}));
        r.y = '0;
        r.z = z;
        if (z > QUARTER_TURN || z < -QUARTER_TURN) begin
            r.x = -r.x;
            r.z = z[32] ? z + HALF_TURN : z - HALF_TURN;
        end
        return r;
    endfunction

    // back to q8.8 rounding half up
    function automatic logic signed [UW-1:0] unguard(input logic signed [VW-1:0] v);
        logic signed [VW:0] t;
        t = {v[VW-1], v}
            + {{(VW + 1 - pvu_pkg::GUARD){1'b0}}, 1'b1, {(pvu_pkg::GUARD - 1){1'b0}}};
        return UW'(t >>> pvu_pkg::GUARD);
    endfunction

    logic                   accept;
    logic [N+2:0]           r_v1;
    logic [N+3:0]           r_v2;
    t_side1                 r_side1 [0:N+2];
    t_side2                 r_side2 [0:N+3];
    pvu_pkg::t_rot          r_pre_a;
    pvu_pkg::t_rot          r_pre_b;
    pvu_pkg::t_rot          rot_a [0:N];
    pvu_pkg::t_rot          rot_b [0:N];
    logic signed [RW-1:0]   g_ax;
    logic signed [RW-1:0]   g_ay;
    logic signed [RW-1:0]   g_bx;
    logic signed [RW-1:0]   g_by;
    logic signed [VW-1:0]   n_cx;
    logic signed [VW-1:0]   n_cy;
    logic signed [VW-1:0]   r_cx;
    logic signed [VW-1:0]   r_cy;
    pvu_pkg::t_vec          n_pre_v;
    pvu_pkg::t_vec          r_pre_v;
    pvu_pkg::t_vec          vec [0:N];
    logic signed [VW-1:0]   g_mag;
    logic [31:0]            r_zd [0:1];
    logic signed [UW-1:0]   ux;
    logic signed [UW-1:0]   uy;
    logic signed [UW-1:0]   um;
    logic [31:0]            ang_r;
    pvu_pkg::t_result       n_res;
    pvu_pkg::t_result       r_res;
    logic                   r_out_valid;

    // no stall anywhere in the pipe
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // valid bits, the only control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= '0;
            r_v2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1        <= {r_v1[N+1:0], accept};
            r_v2        <= {r_v2[N+2:0], r_v1[N+2]};
            r_out_valid <= r_v2[N+3];
        end
    end

    // input stage: pre-rotation of both lanes
    always_ff @(posedge i_clk) begin
        r_pre_a        <= pre_rotate(i_operands.a_magnitude, i_operands.a_angle);
        r_pre_b        <= pre_rotate(i_operands.b_magnitude, i_operands.b_angle);
        r_side1[0]     <= '{action: i_operands.action,
                            px: i_operands.point_x,
                            py: i_operands.point_y};
    end

    assign rot_a[0] = r_pre_a;
    assign rot_b[0] = r_pre_b;

    for (genvar k = 0; k < N; k++) begin : g_rot
        pvu_rot_step #(.STEP(k)) u_step_a (
            .i_clk (i_clk),
            .i_s   (rot_a[k]),
            .o_s   (rot_a[k+1])
        );
        pvu_rot_step #(.STEP(k)) u_step_b (
            .i_clk (i_clk),
            .i_s   (rot_b[k]),
            .o_s   (rot_b[k+1])
        );
    end

    for (genvar k = 0; k < N + 2; k++) begin : g_side1
        always_ff @(posedge i_clk) begin
            r_side1[k+1] <= r_side1[k];
        end
    end

    pvu_gain #(.W(RW)) u_gain_ax (.i_clk(i_clk), .i_v(rot_a[N].x), .o_p(g_ax));
    pvu_gain #(.W(RW)) u_gain_ay (.i_clk(i_clk), .i_v(rot_a[N].y), .o_p(g_ay));
    pvu_gain #(.W(RW)) u_gain_bx (.i_clk(i_clk), .i_v(rot_b[N].x), .o_p(g_bx));
    pvu_gain #(.W(RW)) u_gain_by (.i_clk(i_clk), .i_v(rot_b[N].y), .o_p(g_by));

    // combine stage: pick the vector to be measured
    always_comb begin
        case (r_side1[N+2].action)
            pvu_pkg::ACT_TO_POLAR: begin
                n_cx = VW'(signed'({r_side1[N+2].px, {pvu_pkg::GUARD{1'b0}}}));
                n_cy = VW'(signed'({r_side1[N+2].py, {pvu_pkg::GUARD{1'b0}}}));
            end
            pvu_pkg::ACT_ADD: begin
                n_cx = VW'(g_ax) + VW'(g_bx);
                n_cy = VW'(g_ay) + VW'(g_by);
            end
            pvu_pkg::ACT_SUB: begin
                n_cx = VW'(g_ax) - VW'(g_bx);
                n_cy = VW'(g_ay) - VW'(g_by);
            end
            default: begin
                n_cx = VW'(g_ax);
                n_cy = VW'(g_ay);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_side2[0] <= '{action: r_side1[N+2].action, ax: g_ax, ay: g_ay};
    end

    // fold the left half-plane onto the right, starting the angle at pi
    always_comb begin
        if (r_cx[VW-1]) begin
            n_pre_v.x = -r_cx;
            n_pre_v.y = -r_cy;
            n_pre_v.z = 32'h8000_0000;
        end else begin
            n_pre_v.x = r_cx;
            n_pre_v.y = r_cy;
            n_pre_v.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pre_v <= n_pre_v;
    end

    assign vec[0] = r_pre_v;

    for (genvar k = 0; k < N; k++) begin : g_vec
        pvu_vec_step #(.STEP(k)) u_step (
            .i_clk (i_clk),
            .i_s   (vec[k]),
            .o_s   (vec[k+1])
        );
    end

    for (genvar k = 0; k < N + 3; k++) begin : g_side2
        always_ff @(posedge i_clk) begin
            r_side2[k+1] <= r_side2[k];
        end
    end

    pvu_gain #(.W(VW)) u_gain_mag (.i_clk(i_clk), .i_v(vec[N].x), .o_p(g_mag));

    // angle waits out the gain multiplier
    always_ff @(posedge i_clk) begin
        r_zd[0] <= vec[N].z;
        r_zd[1] <= r_zd[0];
    end

    // output stage: rounding, saturation and field selection
    always_comb begin
        ux    = unguard(VW'(r_side2[N+3].ax));
        uy    = unguard(VW'(r_side2[N+3].ay));
        um    = unguard(g_mag);
        ang_r = r_zd[1] + 32'h0000_8000;
        n_res = '0;
        if (r_side2[N+3].action == pvu_pkg::ACT_TO_CART) begin
            if (ux > SMAX) begin
                n_res.out_x    = SMAX[pvu_pkg::COORD_WIDTH-1:0];
                n_res.overflow = 1'b1;
            end else if (ux < SMIN) begin
                n_res.out_x    = SMIN[pvu_pkg::COORD_WIDTH-1:0];
                n_res.overflow = 1'b1;
            end else begin
                n_res.out_x    = ux[pvu_pkg::COORD_WIDTH-1:0];
            end
            if (uy > SMAX) begin
                n_res.out_y    = SMAX[pvu_pkg::COORD_WIDTH-1:0];
                n_res.overflow = 1'b1;
            end else if (uy < SMIN) begin
                n_res.out_y    = SMIN[pvu_pkg::COORD_WIDTH-1:0];
                n_res.overflow = 1'b1;
            end else begin
                n_res.out_y    = uy[pvu_pkg::COORD_WIDTH-1:0];
            end
        end else begin
            if (um > UMAX) begin
                n_res.out_magnitude = UMAX[pvu_pkg::COORD_WIDTH-1:0];
                n_res.overflow      = 1'b1;
            end else if (um < 0) begin
                n_res.out_magnitude = '0;
                n_res.overflow      = 1'b1;
            end else begin
                n_res.out_magnitude = um[pvu_pkg::COORD_WIDTH-1:0];
            end
            // zero length has no direction
            if (n_res.out_magnitude != '0) begin
                n_res.out_angle = signed'(ang_r[31 -: pvu_pkg::ANGLE_WIDTH]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_res;

    // every accepted item comes out after the fixed latency
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("accepted item did not emerge after fixed latency");

    // no result without an item accepted at the matching edge
    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, LATENCY))
        else $error("result with no matching accepted item");

    // cartesian and polar fields are never both in use
    a_field_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.out_x == '0 && o_result.out_y == '0)
                 || (o_result.out_magnitude == '0 && o_result.out_angle == '0))
        else $error("cartesian and polar result fields both set");

    // a zero length carries angle zero
    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.out_magnitude == '0) |-> o_result.out_angle == '0)
        else $error("nonzero angle on zero magnitude");

endmodule
